>>> design/ps2mq_pkg.sv
// shared constants and codes for the ps/2 mouse packet queue
`default_nettype none

package ps2mq_pkg;

  localparam int NUM_FOCUS_DEF   = 4;
  localparam int QUEUE_BYTES_DEF = 512;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic [1:0] OP_REL  = 2'd0;
  localparam logic [1:0] OP_BTN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_ABS  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [7:0] PKT_SYNC = 8'h08;
  localparam logic [2:0] BTN_MASK = 3'h7;
  localparam logic [7:0] SIGN_X   = 8'h10;
  localparam logic [7:0] SIGN_Y   = 8'h20;

endpackage

`default_nettype wire

>>> design/ps2_mouse_packet_queue.sv
// ps/2 mouse packet queue: per-focus byte queues held in one synchronous ram
//
// Input stream (in_t*): one request per item, opcode selects relative motion,
// button change, single byte read or absolute motion (ignored). Every request
// gives exactly one result on the output stream (out_t*): a status code and
// the popped byte for a successful read.
// One request is in flight at a time; in_tready is high only while idle.
// Path from acceptance to the result register, with the output free:
//   ignored, unchanged, full or empty  - straight to S_DONE
//   byte read                          - S_READ (registered ram read)
//   queued packet                      - S_PUSH (three bytes through the
//                                        single ram write port)
// The next request can be taken in the same cycle that out_tvalid rises,
// while the result may still sit in the output register.
// When the receiver stalls, the result holds in the output register; one
// further request is processed and then waits until that register frees.
// Reset clears pointers, held buttons and the output valid flag; queue ram
// contents are never cleared, only read after being written.
`default_nettype none

module ps2_mouse_packet_queue #(
  parameter int NUM_FOCUS   = ps2mq_pkg::NUM_FOCUS_DEF,
  parameter int QUEUE_BYTES = ps2mq_pkg::QUEUE_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // opcode[1:0], focus[4:2], dx[20:5], dy[36:21], button_state[44:37]
  input  wire logic [ps2mq_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status[1:0], read_byte[9:2]
  output logic [ps2mq_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import ps2mq_pkg::*;

  localparam int PTR_W  = $clog2(2 * QUEUE_BYTES);
  localparam int SLOT_W = $clog2(QUEUE_BYTES);
  localparam int DEPTH  = NUM_FOCUS * QUEUE_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FOC_W  = (NUM_FOCUS > 1) ? $clog2(NUM_FOCUS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(2 * QUEUE_BYTES - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= PTR_W'(QUEUE_BYTES)) ? p - PTR_W'(QUEUE_BYTES) : p;
    slot_of = s[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [FOC_W-1:0] f,
                                                input logic [PTR_W-1:0] p);
    addr_of = ADDR_W'(f) * ADDR_W'(QUEUE_BYTES) + ADDR_W'(slot_of(p));
  endfunction

  // input fields
  logic [1:0]  in_opcode;
  logic [2:0]  in_focus;
  logic [15:0] in_dx;
  logic [15:0] in_dy;
  logic [7:0]  in_button_state;

  assign in_opcode       = in_tdata[1:0];
  assign in_focus        = in_tdata[4:2];
  assign in_dx           = in_tdata[20:5];
  assign in_dy           = in_tdata[36:21];
  assign in_button_state = in_tdata[44:37];

  // state
  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] wr_ptr_r [NUM_FOCUS];
  logic [PTR_W-1:0] rd_ptr_r [NUM_FOCUS];
  logic [2:0]       held_r   [NUM_FOCUS];
  logic [7:0]       byte_store [DEPTH];

  logic [FOC_W-1:0] pfoc_r;
  logic [7:0]       b0_r, b1_r, b2_r;
  logic [1:0]       cnt_r;
  logic [1:0]       res_status_r;
  logic [7:0]       res_byte_r;
  logic [7:0]       rd_data_r;
  logic             out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // decode of the offered request
  logic             accept;
  logic             foc_ok;
  logic [FOC_W-1:0] fidx;
  logic [PTR_W-1:0] cur_wr, cur_rd;
  logic [PTR_W:0]   pend;
  logic             q_full, q_empty;
  logic [2:0]       new_btn;
  logic             y_neg;
  logic [7:0]       y_low;

  logic             start_push, start_read, set_held;
  logic [1:0]       dec_status;
  logic [7:0]       dec_b0, dec_b1, dec_b2;

  logic             mem_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]       wdata;
  logic             out_load;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign foc_ok = ({1'b0, in_focus} < 4'(NUM_FOCUS));
  assign fidx   = FOC_W'(in_focus);
  assign cur_wr = wr_ptr_r[fidx];
  assign cur_rd = rd_ptr_r[fidx];

  always_comb begin
    pend = {1'b0, cur_wr} - {1'b0, cur_rd};
    if (cur_wr < cur_rd) begin
      pend = pend + (PTR_W + 1)'(2 * QUEUE_BYTES);
    end
  end

  assign q_full  = (pend > (PTR_W + 1)'(QUEUE_BYTES - 3));
  assign q_empty = (pend == '0);
  assign new_btn = in_button_state[2:0] & BTN_MASK;
  // negated dy is negative exactly when dy is positive
  assign y_neg   = !in_dy[15] && (in_dy != '0);
  assign y_low   = ~in_dy[7:0] + 8'd1;

  always_comb begin
    start_push = 1'b0;
    start_read = 1'b0;
    set_held   = 1'b0;
    dec_status = ST_IGNORED;
    dec_b0     = PKT_SYNC;
    dec_b1     = '0;
    dec_b2     = '0;
    if (foc_ok) begin
      case (in_opcode)
        OP_REL: begin
          dec_b0 = PKT_SYNC | {5'd0, held_r[fidx]}
                 | (in_dx[15] ? SIGN_X : 8'd0) | (y_neg ? SIGN_Y : 8'd0);
          dec_b1 = in_dx[7:0];
          dec_b2 = y_low;
          if (q_full) begin
            dec_status = ST_FULL;
          end else begin
            dec_status = ST_DONE;
            start_push = 1'b1;
          end
        end
        OP_BTN: begin
          dec_b0 = PKT_SYNC | {5'd0, new_btn};
          if (new_btn != held_r[fidx]) begin
            if (q_full) begin
              dec_status = ST_FULL;
            end else begin
              dec_status = ST_DONE;
              start_push = 1'b1;
              set_held   = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (q_empty) begin
            dec_status = ST_EMPTY;
          end else begin
            dec_status = ST_DONE;
            start_read = 1'b1;
          end
        end
        default: begin
          dec_status = ST_IGNORED;
        end
      endcase
    end
  end

  // ram access
  assign raddr  = addr_of(fidx, cur_rd);
  assign waddr  = addr_of(pfoc_r, wr_ptr_r[pfoc_r]);
  assign mem_we = (state_r == S_PUSH);

  always_comb begin
    case (cnt_r)
      2'd0:    wdata = b0_r;
      2'd1:    wdata = b1_r;
      default: wdata = b2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[waddr] <= wdata;
    end
    if (accept && start_read) begin
      rd_data_r <= byte_store[raddr];
    end
  end

  // sequencer
  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (start_push) begin
            state_nxt = S_PUSH;
          end else if (start_read) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_PUSH: begin
        if (cnt_r == 2'd2) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NUM_FOCUS; i++) begin
        wr_ptr_r[i] <= '0;
        rd_ptr_r[i] <= '0;
        held_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
        if (set_held) begin
          held_r[fidx] <= new_btn;
        end
        if (start_read) begin
          rd_ptr_r[fidx] <= ptr_inc(cur_rd);
        end
      end
      if (mem_we) begin
        cnt_r            <= cnt_r + 2'd1;
        wr_ptr_r[pfoc_r] <= ptr_inc(wr_ptr_r[pfoc_r]);
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pfoc_r       <= fidx;
      b0_r         <= dec_b0;
      b1_r         <= dec_b1;
      b2_r         <= dec_b2;
      res_status_r <= dec_status;
      res_byte_r   <= '0;
    end
    if (state_r == S_READ) begin
      res_byte_r <= rd_data_r;
    end
    if (out_load) begin
      out_tdata_r <= {{(OUT_TDATA_W - 10){1'b0}}, res_byte_r, res_status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

>>> design/ps2mq_checker.sv
// port-level checks for the ps/2 mouse packet queue
`default_nettype none

module ps2mq_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [ps2mq_pkg::IN_TDATA_W-1:0]    in_tdata,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [ps2mq_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ps2mq_pkg::*;

  // only a successful read carries a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_DONE) |-> out_tdata[9:2] == 8'd0)
    else $error("result byte non-zero on a status without a read");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // one request at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // no pad bits set on the result
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:10] == '0)
    else $error("result padding non-zero");

endmodule

bind ps2_mouse_packet_queue ps2mq_checker u_ps2mq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
